/* hw/rtl/sfk_pkg.sv */
// Shared types and constants of the symmetric flow key extractor.
package sfk_pkg;

    localparam logic [15:0] VLAN_TPID_RESET = 16'h8100;
    localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_TCP       = 8'd6;
    localparam logic [7:0]  TCP_MARK        = 8'h40;
    localparam logic [11:0] TAG_MASK        = 12'hfff;
    localparam logic [13:0] FRAG_MASK       = 14'h3fff;

    localparam logic [6:0]  OFS_TYPE_HI     = 7'd12;
    localparam logic [6:0]  OFS_TYPE_LO     = 7'd13;
    localparam logic [6:0]  OFS_TAG_HI      = 7'd14;
    localparam logic [6:0]  OFS_TAG_LO      = 7'd15;
    localparam logic [6:0]  OFS_INNER_HI    = 7'd16;
    localparam logic [6:0]  OFS_INNER_LO    = 7'd17;
    localparam logic [6:0]  L3_UNTAGGED     = 7'd14;
    localparam logic [6:0]  L3_TAGGED       = 7'd18;
    localparam logic [6:0]  OFS_MAX         = 7'd127;
    localparam logic [3:0]  IHL_MIN         = 4'd5;
    localparam logic [7:0]  TCP_HDR_BYTES   = 8'd20;

    // APB register indexes (word address paddr[2])
    localparam logic        REG_VLAN_TPID   = 1'b0;

    typedef struct packed {
        logic [6:0]  byte_offset;
        logic        is_tagged;
        logic [15:0] outer_type;
        logic [11:0] tag_id;
        logic [3:0]  header_words;
        logic [7:0]  proto_byte;
        logic [13:0] frag_field;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  flag_byte;
    } t_frame_state;

    typedef struct packed {
        logic [31:0] first_addr;
        logic [31:0] second_addr;
        logic [15:0] first_port;
        logic [15:0] second_port;
        logic [11:0] vlan_id;
        logic        net_kind;
        logic        trans_kind;
        logic [7:0]  tcp_flag_bits;
    } t_flow_key;

endpackage

/* hw/rtl/sfk_capture.sv */
// Per-frame header capture: holds frame state and captures each byte by offset.
module sfk_capture import sfk_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  logic [7:0]   i_data_byte,
    input  logic         i_last_byte,
    input  logic [15:0]  i_vlan_tpid,
    output t_frame_state o_next
);

    t_frame_state r_st;
    t_frame_state n_st;

    logic [6:0]  pos;
    logic [6:0]  l3;
    logic [6:0]  rel;
    logic [6:0]  hw4;
    logic [6:0]  trel;
    logic [15:0] type_shift;

    always_comb begin
        pos        = r_st.byte_offset;
        l3         = r_st.is_tagged ? L3_TAGGED : L3_UNTAGGED;
        rel        = pos - l3;
        hw4        = {1'b0, r_st.header_words, 2'b00};
        trel       = rel - hw4;
        type_shift = {r_st.outer_type[7:0], i_data_byte};

        n_st = r_st;
        n_st.byte_offset = (pos == OFS_MAX) ? OFS_MAX : pos + 7'd1;

        if (pos == OFS_TYPE_HI) begin
            n_st.outer_type = type_shift;
        end else if (pos == OFS_TYPE_LO) begin
            if (type_shift == i_vlan_tpid) begin
                n_st.is_tagged  = 1'b1;
                n_st.outer_type = '0;
            end else begin
                n_st.outer_type = type_shift;
            end
        end else if (r_st.is_tagged && (pos == OFS_TAG_HI || pos == OFS_TAG_LO)) begin
            n_st.tag_id = {r_st.tag_id[3:0], i_data_byte} & TAG_MASK;
        end else if (r_st.is_tagged && (pos == OFS_INNER_HI || pos == OFS_INNER_LO)) begin
            n_st.outer_type = type_shift;
        end else if (pos >= l3) begin
            if (rel == 7'd0) begin
                n_st.header_words = i_data_byte[3:0];
            end else if (rel == 7'd6 || rel == 7'd7) begin
                n_st.frag_field = {r_st.frag_field[5:0], i_data_byte} & FRAG_MASK;
            end else if (rel == 7'd9) begin
                n_st.proto_byte = i_data_byte;
            end else if (rel >= 7'd12 && rel <= 7'd15) begin
                n_st.src_ip = {r_st.src_ip[23:0], i_data_byte};
            end else if (rel >= 7'd16 && rel <= 7'd19) begin
                n_st.dst_ip = {r_st.dst_ip[23:0], i_data_byte};
            end

            // TCP bytes follow the IPv4 header as sized by IHL
            if (r_st.header_words >= IHL_MIN && rel >= hw4) begin
                if (trel <= 7'd1) begin
                    n_st.src_port = {r_st.src_port[7:0], i_data_byte};
                end else if (trel <= 7'd3) begin
                    n_st.dst_port = {r_st.dst_port[7:0], i_data_byte};
                end else if (trel == 7'd13) begin
                    n_st.flag_byte = i_data_byte;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_accept) begin
            r_st <= i_last_byte ? '0 : n_st;
        end
    end

    assign o_next = n_st;

endmodule

/* hw/rtl/sfk_key.sv */
// Flow key formation: validity checks and symmetric ordering of the captured fields.
module sfk_key import sfk_pkg::*; (
    input  t_frame_state i_st,
    output t_flow_key    o_key
);

    logic [7:0] count;
    logic [7:0] l3;
    logic [7:0] ip_end;
    logic [7:0] tcp_end;
    logic       is_ip;
    logic       is_tcp;
    logic       swap;

    always_comb begin
        count   = {1'b0, i_st.byte_offset};
        l3      = {1'b0, (i_st.is_tagged ? L3_TAGGED : L3_UNTAGGED)};
        ip_end  = l3 + {2'b00, i_st.header_words, 2'b00};
        tcp_end = ip_end + TCP_HDR_BYTES;
        swap    = i_st.src_ip < i_st.dst_ip;

        is_ip  = (count >= 8'd14) && (i_st.outer_type == ETHERTYPE_IPV4) &&
                 (i_st.header_words >= IHL_MIN) && (count >= ip_end);
        is_tcp = is_ip && (i_st.proto_byte == PROTO_TCP) &&
                 (i_st.frag_field == '0) && (count >= tcp_end);

        o_key = '0;
        if (count >= 8'd14 && i_st.is_tagged) begin
            o_key.vlan_id = i_st.tag_id;
        end
        if (is_ip) begin
            o_key.net_kind    = 1'b1;
            o_key.first_addr  = swap ? i_st.dst_ip : i_st.src_ip;
            o_key.second_addr = swap ? i_st.src_ip : i_st.dst_ip;
        end
        if (is_tcp) begin
            o_key.trans_kind    = 1'b1;
            o_key.first_port    = swap ? i_st.dst_port : i_st.src_port;
            o_key.second_port   = swap ? i_st.src_port : i_st.dst_port;
            o_key.tcp_flag_bits = i_st.flag_byte | TCP_MARK;
        end
    end

endmodule

/* hw/rtl/symmetric_flow_key_extractor.sv */
// The key is registered and appears in the cycle after the transaction that carries the last byte.
// Throughput: one byte transaction per cycle while the input is not stalled, set by the single capture pass per byte.
// A key waiting at the output holds the input stalled only while the output is stalled.
// Reset (synchronous, i_rst_n low) clears frame state and the output valid,
// and returns vlan_tpid to 0x8100.
module symmetric_flow_key_extractor import sfk_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // byte input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    // flow key output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_first_addr,
    output logic [31:0] o_second_addr,
    output logic [15:0] o_first_port,
    output logic [15:0] o_second_port,
    output logic [11:0] o_vlan_id,
    output logic        o_net_kind,
    output logic        o_trans_kind,
    output logic [7:0]  o_tcp_flag_bits
);

    logic [15:0]  r_vlan_tpid;
    logic         r_out_valid;
    t_flow_key    r_key;

    t_frame_state next_st;
    t_flow_key    key;
    logic         in_accept;
    logic         cfg_write;

    // APB: always ready; write lands on the access cycle.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vlan_tpid <= VLAN_TPID_RESET;
        end else if (cfg_write && paddr[2] == REG_VLAN_TPID) begin
            r_vlan_tpid <= pwdata[15:0];
        end
    end

    // Read back the TPID; unmapped word reads as zero.
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_VLAN_TPID) begin
            prdata = {16'd0, r_vlan_tpid};
        end
    end

    // Stall the input only when a finished key cannot leave this cycle.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Capture this byte into the frame state; next_st is the state after the byte.
    sfk_capture u_capture (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_vlan_tpid (r_vlan_tpid),
        .o_next      (next_st)
    );

    // Form the symmetric key from the state including the last byte.
    sfk_key u_key (
        .i_st  (next_st),
        .o_key (key)
    );

    // Result register: load on the last byte, drop once the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept && i_last_byte) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && i_last_byte) begin
            r_key <= key;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_first_addr    = r_key.first_addr;
    assign o_second_addr   = r_key.second_addr;
    assign o_first_port    = r_key.first_port;
    assign o_second_port   = r_key.second_port;
    assign o_vlan_id       = r_key.vlan_id;
    assign o_net_kind      = r_key.net_kind;
    assign o_trans_kind    = r_key.trans_kind;
    assign o_tcp_flag_bits = r_key.tcp_flag_bits;

endmodule

/* hw/rtl/sfk_checker.sv */
// Port-level checker for the flow key extractor, bound to the top level.
module sfk_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        i_last_byte,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [31:0] o_first_addr,
    input logic [31:0] o_second_addr,
    input logic [15:0] o_first_port,
    input logic [15:0] o_second_port,
    input logic        o_net_kind,
    input logic        o_trans_kind,
    input logic [7:0]  o_tcp_flag_bits
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    a_last_gives_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_last_byte |=> o_out_valid)
        else $error("no key after last byte");

    a_non_ip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_net_kind |->
            o_first_addr == 32'd0 && o_second_addr == 32'd0 && !o_trans_kind)
        else $error("non-IPv4 key carries addresses or TCP kind");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_net_kind |-> o_first_addr >= o_second_addr)
        else $error("addresses not in symmetric order");

    a_tcp_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_trans_kind ? o_tcp_flag_bits[6] :
            (o_first_port == 16'd0 && o_second_port == 16'd0 &&
             o_tcp_flag_bits == 8'd0)))
        else $error("TCP fields inconsistent with trans_kind");

endmodule

bind symmetric_flow_key_extractor sfk_checker u_sfk_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .i_last_byte     (i_last_byte),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_first_addr    (o_first_addr),
    .o_second_addr   (o_second_addr),
    .o_first_port    (o_first_port),
    .o_second_port   (o_second_port),
    .o_net_kind      (o_net_kind),
    .o_trans_kind    (o_trans_kind),
    .o_tcp_flag_bits (o_tcp_flag_bits)
);
